FILE: rtl/core/range_add_range_sum_store_macros.svh
// Assertion macros shared by the range add / range sum store checkers.
`ifndef RANGE_ADD_RANGE_SUM_STORE_MACROS_SVH
`define RANGE_ADD_RANGE_SUM_STORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RARS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rars check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define RARS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rars check failed");

`endif

FILE: rtl/core/rars_pkg.sv
// Package: sizes, codes and shared types of the range add / range sum store.
`default_nettype none

package rars_pkg;

  localparam int unsigned MaxElems  = 1024;
  // Block length must be a power of two: block number and offset are bit fields.
  localparam int unsigned BlockLen  = 32;
  localparam int unsigned NumBlocks = (MaxElems + BlockLen - 1) / BlockLen;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned OffW      = $clog2(BlockLen);
  localparam int unsigned BlkW      = IdxW - OffW;
  localparam int unsigned DataW     = 64;

  localparam logic KindAdd     = 1'b0;
  localparam logic KindQuery   = 1'b1;
  localparam logic StatusDone  = 1'b0;
  localparam logic StatusBad   = 1'b1;

  typedef enum logic [2:0] {
    AluElemAmt,
    AluElemTag,
    AluSumAmt,
    AluTagAmt,
    AluSumTag,
    AluAccTmp
  } alu_op_e;

  typedef struct packed {
    logic             elem_we;
    logic [IdxW-1:0]  elem_addr;
    logic [DataW-1:0] elem_wdata;
    logic             sum_we;
    logic             tag_we;
    logic [BlkW-1:0]  blk_addr;
    logic [DataW-1:0] blk_wdata;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/rars_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module rars_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/rars_alu.sv
// Shared 64-bit adder with operand selection.
`default_nettype none

module rars_alu (
  input  rars_pkg::alu_op_e           op_i,
  input  logic [rars_pkg::DataW-1:0]  elem_i,
  input  logic [rars_pkg::DataW-1:0]  sum_i,
  input  logic [rars_pkg::DataW-1:0]  tag_i,
  input  logic [rars_pkg::DataW-1:0]  amount_i,
  input  logic [rars_pkg::DataW-1:0]  acc_i,
  input  logic [rars_pkg::DataW-1:0]  tmp_i,
  output logic [rars_pkg::DataW-1:0]  y_o
);
  import rars_pkg::*;

  logic [DataW-1:0] a;
  logic [DataW-1:0] b;

  always_comb begin
    case (op_i)
      AluElemAmt: begin a = elem_i; b = amount_i; end
      AluElemTag: begin a = elem_i; b = tag_i;    end
      AluSumAmt:  begin a = sum_i;  b = amount_i; end
      AluTagAmt:  begin a = tag_i;  b = amount_i; end
      // full block: its sum plus its tag once per element
      AluSumTag:  begin a = sum_i;  b = tag_i << OffW; end
      AluAccTmp:  begin a = acc_i;  b = tmp_i;    end
      default:    begin a = acc_i;  b = tmp_i;    end
    endcase
    y_o = a + b;
  end

endmodule

`default_nettype wire

FILE: rtl/core/rars_ctrl.sv
// Sequencer: clearing pass, element and block walk, result hand-off.
`default_nettype none

module rars_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        bad_i,
  input  logic                        kind_i,
  input  logic [rars_pkg::IdxW-1:0]   first_i,
  input  logic [rars_pkg::IdxW-1:0]   last_i,
  input  logic [rars_pkg::DataW-1:0]  amount_i,
  input  logic                        out_free_i,
  input  logic [rars_pkg::DataW-1:0]  elem_rd_i,
  input  logic [rars_pkg::DataW-1:0]  sum_rd_i,
  input  logic [rars_pkg::DataW-1:0]  tag_rd_i,
  output rars_pkg::mem_req_t          mem_req_o,
  output logic                        ready_o,
  output logic                        res_valid_o,
  output logic [rars_pkg::DataW-1:0]  res_sum_o,
  output logic                        res_status_o
);
  import rars_pkg::*;

  localparam logic [2:0] SClr  = 3'd0;
  localparam logic [2:0] SIdle = 3'd1;
  localparam logic [2:0] SRd   = 3'd2;
  localparam logic [2:0] SE1   = 3'd3;
  localparam logic [2:0] SE2   = 3'd4;
  localparam logic [2:0] SB1   = 3'd5;
  localparam logic [2:0] SB2   = 3'd6;
  localparam logic [2:0] SFin  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  cur_q, cur_d;
  logic [IdxW-1:0]  hi_q, hi_d;
  logic [BlkW-1:0]  p_q, p_d, q_q, q_d;
  logic             kind_q, kind_d;
  logic             status_q, status_d;
  logic             mid_q, mid_d;
  logic [DataW-1:0] amt_q, amt_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] tmp_q, tmp_d;

  logic [BlkW-1:0]  cur_blk;
  logic             cur_mid;
  logic [CntW-1:0]  cur_next;
  logic             walk_end;
  alu_op_e          alu_op;
  logic [DataW-1:0] alu_y;

  assign cur_blk  = cur_q[IdxW-1:OffW];
  assign cur_mid  = (cur_blk > p_q) && (cur_blk < q_q);
  assign cur_next = mid_q ? cur_q + CntW'(BlockLen) : cur_q + CntW'(1);
  assign walk_end = cur_next > {1'b0, hi_q};

  always_comb begin
    case (state_q)
      SE1:     alu_op = (kind_q == KindQuery) ? AluElemTag : AluElemAmt;
      SE2:     alu_op = (kind_q == KindQuery) ? AluAccTmp  : AluSumAmt;
      SB1:     alu_op = (kind_q == KindQuery) ? AluSumTag  : AluTagAmt;
      default: alu_op = AluAccTmp;
    endcase
  end

  rars_alu u_alu (
    .op_i     (alu_op),
    .elem_i   (elem_rd_i),
    .sum_i    (sum_rd_i),
    .tag_i    (tag_rd_i),
    .amount_i (amt_q),
    .acc_i    (acc_q),
    .tmp_i    (tmp_q),
    .y_o      (alu_y)
  );

  always_comb begin
    mem_req_o.elem_addr  = cur_q[IdxW-1:0];
    mem_req_o.blk_addr   = (state_q == SClr) ? cur_q[BlkW-1:0] : cur_blk;
    mem_req_o.elem_wdata = (state_q == SClr) ? '0 : alu_y;
    mem_req_o.blk_wdata  = (state_q == SClr) ? '0 : alu_y;
    mem_req_o.elem_we    = (state_q == SClr) || (state_q == SE1 && kind_q == KindAdd);
    mem_req_o.sum_we     = (state_q == SClr) || (state_q == SE2 && kind_q == KindAdd);
    mem_req_o.tag_we     = (state_q == SClr) || (state_q == SB1 && kind_q == KindAdd);
  end

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    hi_d     = hi_q;
    p_d      = p_q;
    q_d      = q_q;
    kind_d   = kind_q;
    status_d = status_q;
    mid_d    = mid_q;
    amt_d    = amt_q;
    acc_d    = acc_q;
    tmp_d    = tmp_q;
    case (state_q)
      SClr: begin
        cur_d = cur_q + CntW'(1);
        if (cur_q[IdxW-1:0] == IdxW'(MaxElems - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (start_i) begin
          cur_d    = {1'b0, first_i};
          hi_d     = last_i;
          p_d      = first_i[IdxW-1:OffW];
          q_d      = last_i[IdxW-1:OffW];
          kind_d   = kind_i;
          amt_d    = amount_i;
          acc_d    = '0;
          status_d = bad_i ? StatusBad : StatusDone;
          state_d  = bad_i ? SFin : SRd;
        end
      end
      SRd: begin
        mid_d   = cur_mid;
        state_d = cur_mid ? SB1 : SE1;
      end
      SE1: begin
        if (kind_q == KindQuery) begin
          tmp_d = alu_y;
        end
        state_d = SE2;
      end
      SE2: begin
        if (kind_q == KindQuery) begin
          acc_d = alu_y;
        end
        cur_d   = cur_next;
        state_d = walk_end ? SFin : SRd;
      end
      SB1: begin
        if (kind_q == KindQuery) begin
          tmp_d   = alu_y;
          state_d = SB2;
        end else begin
          cur_d   = cur_next;
          state_d = walk_end ? SFin : SRd;
        end
      end
      SB2: begin
        acc_d   = alu_y;
        cur_d   = cur_next;
        state_d = walk_end ? SFin : SRd;
      end
      SFin: begin
        if (out_free_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q     <= hi_d;
    p_q      <= p_d;
    q_q      <= q_d;
    kind_q   <= kind_d;
    status_q <= status_d;
    mid_q    <= mid_d;
    amt_q    <= amt_d;
    acc_q    <= acc_d;
    tmp_q    <= tmp_d;
  end

  assign ready_o      = (state_q == SIdle);
  assign res_valid_o  = (state_q == SFin) && out_free_i;
  assign res_sum_o    = acc_q;
  assign res_status_o = status_q;

endmodule

`default_nettype wire

FILE: rtl/core/range_add_range_sum_store.sv
// After reset a clearing pass zeroes every store, with the input stalled meanwhile.
// Per item: a bad range goes straight to the result; else the partial-block
// elements are walked one by one and each fully covered block as a whole.
// Throughput: one item at a time, paced by the single shared 64-bit adder.
// Reset: asynchronous active low; clears control state and elem_count to 1024.
`default_nettype none

module range_add_range_sum_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration: elem_count
  input  logic                             cfg_we_i,
  input  logic [rars_pkg::CntW-1:0]        cfg_wdata_i,
  // input item channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic [rars_pkg::IdxW-1:0]        first_index_i,
  input  logic [rars_pkg::IdxW-1:0]        last_index_i,
  input  logic signed [rars_pkg::DataW-1:0] amount_i,
  // result item channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [rars_pkg::DataW-1:0] range_sum_o,
  output logic                             status_o
);
  import rars_pkg::*;

  // elem_count register; values above capacity act as full capacity
  logic [CntW-1:0] elem_count_q;
  logic [CntW-1:0] count_eff;
  logic            bad_range;
  logic            in_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_count_q <= CntW'(1024);
    end else if (cfg_we_i) begin
      elem_count_q <= cfg_wdata_i;
    end
  end

  assign count_eff = (elem_count_q > CntW'(MaxElems)) ? CntW'(MaxElems) : elem_count_q;

  // Reject reversed ranges and ranges past the active count (a zero count
  // rejects everything).
  assign bad_range = (first_index_i > last_index_i) ||
                     ({1'b0, last_index_i} >= count_eff);

  logic ready;
  assign in_stall_o = !ready;
  assign in_accept  = in_valid_i && ready;

  // Output register: a finished result waits here so the sequencer can take
  // the next item while the downstream side stalls.
  logic             out_valid_q;
  logic [DataW-1:0] out_sum_q;
  logic             out_status_q;
  logic             out_free;
  logic             res_valid;
  logic [DataW-1:0] res_sum;
  logic             res_status;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Adds report zero; the accumulator is cleared at the start and not updated for them.
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_sum_q    <= res_sum;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign range_sum_o = $signed(out_sum_q);
  assign status_o    = out_status_q;

  // Stores: elements, per-block sums and per-block pending tags.
  mem_req_t         mem_req;
  logic [DataW-1:0] elem_rd;
  logic [DataW-1:0] sum_rd;
  logic [DataW-1:0] tag_rd;

  rars_ram #(.Width(DataW), .Depth(MaxElems)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.elem_we),
    .waddr_i (mem_req.elem_addr),
    .wdata_i (mem_req.elem_wdata),
    .raddr_i (mem_req.elem_addr),
    .rdata_o (elem_rd)
  );

  rars_ram #(.Width(DataW), .Depth(NumBlocks)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.sum_we),
    .waddr_i (mem_req.blk_addr),
    .wdata_i (mem_req.blk_wdata),
    .raddr_i (mem_req.blk_addr),
    .rdata_o (sum_rd)
  );

  rars_ram #(.Width(DataW), .Depth(NumBlocks)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.tag_we),
    .waddr_i (mem_req.blk_addr),
    .wdata_i (mem_req.blk_wdata),
    .raddr_i (mem_req.blk_addr),
    .rdata_o (tag_rd)
  );

  // Sequencer: walks partial-block elements one by one and covered blocks
  // one block at a time, all arithmetic through one adder.
  rars_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_accept),
    .bad_i        (bad_range),
    .kind_i       (kind_i),
    .first_i      (first_index_i),
    .last_i       (last_index_i),
    .amount_i     (amount_i),
    .out_free_i   (out_free),
    .elem_rd_i    (elem_rd),
    .sum_rd_i     (sum_rd),
    .tag_rd_i     (tag_rd),
    .mem_req_o    (mem_req),
    .ready_o      (ready),
    .res_valid_o  (res_valid),
    .res_sum_o    (res_sum),
    .res_status_o (res_status)
  );

endmodule

`default_nettype wire

FILE: rtl/core/rars_checker.sv
// Port-level checker for the range add / range sum store, bound to the top level.
`default_nettype none

`include "range_add_range_sum_store_macros.svh"

module rars_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic signed [rars_pkg::DataW-1:0] range_sum_o,
  input  logic                              status_o
);

  // one item at a time: an accepted item blocks the next edge
  `RARS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // a rejected range reports a zero sum
  `RARS_ASSERT_SAME(a_bad_zero_sum, out_valid_o && status_o, range_sum_o == '0)
  // hold the result while stalled
  `RARS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `RARS_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i,
                    $stable(range_sum_o) && $stable(status_o))

endmodule

bind range_add_range_sum_store rars_checker u_rars_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .range_sum_o (range_sum_o),
  .status_o    (status_o)
);

`default_nettype wire

FILE: dv/range_add_range_sum_store_tb.sv
// Testbench for the range add / range sum store: directed and random items against a model.
`timescale 1ns / 1ps

module range_add_range_sum_store_tb;
  import rars_pkg::*;

  // Expected outcome of one item: the wrapped range sum and the status bit.
  typedef struct {
    logic signed [DataW-1:0] sum;
    logic                    status;
  } range_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CntW-1:0]         cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    kind_i;
  logic [IdxW-1:0]         first_index_i;
  logic [IdxW-1:0]         last_index_i;
  logic signed [DataW-1:0] amount_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [DataW-1:0] range_sum_o;
  logic                    status_o;

  range_add_range_sum_store dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .first_index_i (first_index_i),
    .last_index_i  (last_index_i),
    .amount_i      (amount_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .range_sum_o   (range_sum_o),
    .status_o      (status_o)
  );

  // 8 ns clock period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Model state: the element store, per-block sums and pending add tags,
  // plus the element count register. All of it mirrors the reset values.
  logic [DataW-1:0] elem_val [MaxElems];
  logic [DataW-1:0] blk_sum  [NumBlocks];
  logic [DataW-1:0] blk_tag  [NumBlocks];
  logic [CntW-1:0]  count_reg = 11'd1024;

  // Outcomes of accepted items, oldest first, waiting for their result item.
  range_result_t pending_sums[$];
  int unsigned   error_count = 0;
  // When set, both sides run back to back with no idle cycles.
  bit            steady = 1'b0;

  initial begin
    for (int i = 0; i < MaxElems; i++) elem_val[i] = '0;
    for (int b = 0; b < NumBlocks; b++) begin
      blk_sum[b] = '0;
      blk_tag[b] = '0;
    end
  end

  function automatic void add_elem(int i, logic [DataW-1:0] amt);
    elem_val[i]           += amt;
    blk_sum[i / BlockLen] += amt;
  endfunction

  function automatic logic [DataW-1:0] read_elem(int i);
    return elem_val[i] + blk_tag[i / BlockLen];
  endfunction

  // Apply one item to the model and return the outcome the block must give.
  // Fully covered blocks take a tag only; partial blocks touch elements.
  function automatic range_result_t run_range_op(logic kd, int lo, int hi,
                                                 logic [DataW-1:0] amt);
    range_result_t    r;
    int               eff;
    int               p;
    int               q;
    logic [DataW-1:0] acc;
    eff      = (count_reg > MaxElems) ? MaxElems : int'(count_reg);
    r.sum    = '0;
    r.status = StatusDone;
    acc      = '0;
    if (lo > hi || hi >= eff) begin
      r.status = StatusBad;
      return r;
    end
    p = lo / BlockLen;
    q = hi / BlockLen;
    if (kd == KindAdd) begin
      if (p == q) begin
        for (int i = lo; i <= hi; i++) add_elem(i, amt);
      end else begin
        for (int b = p + 1; b < q; b++) blk_tag[b] += amt;
        for (int i = lo; i < (p + 1) * BlockLen; i++) add_elem(i, amt);
        for (int i = q * BlockLen; i <= hi; i++) add_elem(i, amt);
      end
      return r;
    end
    if (p == q) begin
      for (int i = lo; i <= hi; i++) acc += read_elem(i);
    end else begin
      for (int b = p + 1; b < q; b++) acc += blk_sum[b] + blk_tag[b] * 64'(BlockLen);
      for (int i = lo; i < (p + 1) * BlockLen; i++) acc += read_elem(i);
      for (int i = q * BlockLen; i <= hi; i++) acc += read_elem(i);
    end
    r.sum = acc;
    return r;
  endfunction

  // Offer one item after a random gap and hold it until the block takes it.
  // Call at a rising edge; returns at the edge that accepted the item.
  // Valid stays high on return so a back-to-back item needs no toggle.
  task automatic send_item(logic kd, int lo, int hi, logic [DataW-1:0] amt);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kd;
    first_index_i <= lo[IdxW-1:0];
    last_index_i  <= hi[IdxW-1:0];
    amount_i      <= amt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_sums.push_back(run_range_op(kd, lo, hi, amt));
  endtask

  // Drop valid and wait until every accepted item has produced its result,
  // then let the block settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the element count while the block is idle.
  task automatic set_count(logic [CntW-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    count_reg  = value;
  endtask

  // Result side: check each accepted result against the oldest outcome and
  // draw a fresh stall length for the next result item.
  initial begin
    int            stall_left;
    range_result_t want;
    stall_left   = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_valid_o && !out_stall_i) begin
          if (pending_sums.size() == 0) begin
            $error("result item with no outstanding item: range_sum %0d status %0b",
                   range_sum_o, status_o);
            error_count++;
          end else begin
            want = pending_sums.pop_front();
            if (range_sum_o !== want.sum) begin
              $error("range_sum mismatch: expected %0d, actual %0d", want.sum, range_sum_o);
              error_count++;
            end
            if (status_o !== want.status) begin
              $error("status mismatch: expected %0b, actual %0b", want.status, status_o);
              error_count++;
            end
          end
          stall_left   = steady ? 0 : $urandom_range(0, 4);
          out_stall_i <= (stall_left != 0);
        end else if (stall_left != 0) begin
          stall_left--;
          if (stall_left == 0) out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Amounts: full 64-bit values, small signed values, 32-bit values and the
  // signed extremes.
  function automatic logic [DataW-1:0] random_amount();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return {$urandom, $urandom};
    if (pick < 8) return 64'($signed($urandom_range(0, 2000)) - 1000);
    if (pick == 8) return {{32{1'b0}}, $urandom};
    case ($urandom_range(0, 3))
      0:       return 64'h7FFF_FFFF_FFFF_FFFF;
      1:       return 64'h8000_0000_0000_0000;
      2:       return '1;
      default: return '0;
    endcase
  endfunction

  // Pick a range under the current count: mostly well-formed ranges of
  // every shape, with a share of bad ones.
  task automatic random_range(output int lo, output int hi);
    int eff;
    int shape;
    int base;
    int top;
    int a;
    int b;
    eff   = (count_reg > MaxElems) ? MaxElems : int'(count_reg);
    shape = $urandom_range(0, 19);
    if (eff == 0) begin
      lo = $urandom_range(0, MaxElems - 1);
      hi = $urandom_range(0, MaxElems - 1);
    end else if (shape < 2) begin
      // bad range: reversed bounds, or past the count where there is room
      if (eff < MaxElems && $urandom_range(0, 1)) begin
        hi = $urandom_range(eff, MaxElems - 1);
        lo = $urandom_range(0, hi);
      end else begin
        lo = $urandom_range(1, MaxElems - 1);
        hi = $urandom_range(0, lo - 1);
      end
    end else if (shape < 7) begin
      // point operation
      lo = $urandom_range(0, eff - 1);
      hi = lo;
    end else if (shape < 10) begin
      // inside one block
      base = $urandom_range(0, (eff - 1) / BlockLen) * BlockLen;
      top  = (base + BlockLen - 1 < eff - 1) ? base + BlockLen - 1 : eff - 1;
      lo   = $urandom_range(base, top);
      hi   = $urandom_range(lo, top);
    end else if (shape < 18) begin
      a  = $urandom_range(0, eff - 1);
      b  = $urandom_range(0, eff - 1);
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
    end else begin
      // near the full span; keep the arithmetic signed for small counts
      lo = $urandom_range(0, (eff - 1 < BlockLen - 1) ? eff - 1 : BlockLen - 1);
      a  = (eff - int'(BlockLen) > lo) ? eff - int'(BlockLen) : lo;
      hi = $urandom_range(a, eff - 1);
    end
  endtask

  // Load extreme values by point adds at the array ends and at a block
  // boundary, then read them back.
  task automatic test_point_load();
    send_item(KindAdd, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(KindAdd, 1023, 1023, 64'h8000_0000_0000_0000);
    send_item(KindAdd, 31, 31, '1);
    send_item(KindAdd, 32, 32, 64'h5555_5555_5555_5555);
    send_item(KindQuery, 0, 0, '0);
    send_item(KindQuery, 1023, 1023, '1);
    send_item(KindQuery, 31, 32, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  // Reversed bounds on both kinds must be flagged and leave the stores alone.
  task automatic test_bad_range();
    send_item(KindAdd, 5, 4, 64'd123);
    send_item(KindQuery, 1023, 0, '1);
  endtask

  // Whole-array add, two partial blocks with nothing between, one block
  // interior, then sums over the whole array and over a span just inside it.
  task automatic test_block_spans();
    send_item(KindAdd, 0, 1023, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(KindAdd, 31, 32, 64'd7);
    send_item(KindAdd, 33, 62, -64'sd5);
    send_item(KindQuery, 0, 1023, '0);
    send_item(KindQuery, 1, 1022, '0);
  endtask

  // Count of zero, of one, and above capacity; end back at full size.
  task automatic test_count_limits();
    set_count(11'd0);
    send_item(KindQuery, 0, 0, '0);
    send_item(KindAdd, 0, 0, 64'd1);
    set_count(11'd1);
    send_item(KindQuery, 0, 0, '0);
    send_item(KindQuery, 0, 1, '0);
    set_count(11'd2047);
    send_item(KindQuery, 0, 1023, '0);
    set_count(11'd1025);
    send_item(KindAdd, 1023, 1023, 64'd1);
    set_count(11'd1024);
  endtask

  // One phase of random traffic under a fixed count.
  task automatic run_phase(logic [CntW-1:0] value, int n, bit no_idle);
    int   lo;
    int   hi;
    logic kd;
    set_count(value);
    steady = no_idle;
    for (int k = 0; k < n; k++) begin
      random_range(lo, hi);
      kd = $urandom_range(0, 1) ? KindQuery : KindAdd;
      send_item(kd, lo, hi, random_amount());
    end
    wait_drained();
    steady = 1'b0;
  endtask

  // Random traffic across counts: full size, above capacity, random sizes,
  // the smallest sizes, and stretches with no idle cycles on either side.
  task automatic test_random_traffic();
    run_phase(11'd1024, 500, 1'b0);
    run_phase(11'd2047, 250, 1'b0);
    run_phase(11'($urandom_range(2, 1023)), 300, 1'b0);
    run_phase(11'd1, 80, 1'b0);
    run_phase(11'd0, 40, 1'b0);
    run_phase(11'd1025, 200, 1'b1);
    run_phase(11'($urandom_range(1, 1024)), 250, 1'b0);
    run_phase(11'd1024, 180, 1'b1);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    kind_i        <= KindAdd;
    first_index_i <= '0;
    last_index_i  <= '0;
    amount_i      <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The clearing pass holds the input stalled; the first item waits it out.
    @(posedge clk_i);

    test_point_load();
    test_bad_range();
    test_block_spans();
    test_count_limits();
    test_random_traffic();

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (error_count == 0 && pending_sums.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
